// ===== hw/rtl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants of the tiled cross-correlator
// station counts, output field widths and the control structs between units
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

    localparam int X_STATIONS       = 3;
    localparam int Y_STATIONS       = 3;
    localparam int POL_PAIRS        = 4;
    localparam int NUM_SUMS         = X_STATIONS * Y_STATIONS * POL_PAIRS;
    localparam int COUNT_BITS       = $clog2(NUM_SUMS + 1);
    localparam int X_IDX_BITS       = (X_STATIONS > 1) ? $clog2(X_STATIONS) : 1;
    localparam int Y_IDX_BITS       = (Y_STATIONS > 1) ? $clog2(Y_STATIONS) : 1;
    localparam int POL_BITS         = 2;
    localparam int IDX_OUT_BITS     = 2;
    localparam int SAMPLE_WORD_BITS = 32;
    localparam int SUM_OUT_BITS     = 32;
    localparam int COMPS            = 4;

    // per-cycle control broadcast to every correlator cell
    typedef struct packed {
        logic acc;      // a step's products are valid at the adders
        logic dump;     // that step closes the integration
        logic shift;    // the dump chain moves one place toward the head
    } cell_ctl_t;

    // status of the output sequencer
    typedef struct packed {
        logic busy;     // dump chain still holds sums to deliver
        logic shift;    // head sum taken this cycle
    } drain_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcc_cell.sv =====
// ----------------------------------------------------------------------------
// tcc_cell: one baseline and polarization pair of the correlator
// multiplies x by conj(y), accumulates with saturation, and holds one link
// of the dump chain
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_cell #(
    parameter int SAMPLE_BITS = 8,
    parameter int ACC_BITS    = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic signed [SAMPLE_BITS-1:0] x_re,
    input  wire logic signed [SAMPLE_BITS-1:0] x_im,
    input  wire logic signed [SAMPLE_BITS-1:0] y_re,
    input  wire logic signed [SAMPLE_BITS-1:0] y_im,
    input  wire tcc_pkg::cell_ctl_t            ctl,
    input  wire logic signed [ACC_BITS-1:0]    chain_re_in,
    input  wire logic signed [ACC_BITS-1:0]    chain_im_in,
    output logic signed [ACC_BITS-1:0]         chain_re_out,
    output logic signed [ACC_BITS-1:0]         chain_im_out
);

    localparam int PW       = 2 * SAMPLE_BITS;
    localparam int CW       = PW + 1;
    localparam int SUM_BITS = ((ACC_BITS > CW) ? ACC_BITS : CW) + 1;

    logic signed [PW-1:0]       p_rr_reg;
    logic signed [PW-1:0]       p_ii_reg;
    logic signed [PW-1:0]       p_ir_reg;
    logic signed [PW-1:0]       p_ri_reg;
    logic signed [ACC_BITS-1:0] acc_re_reg;
    logic signed [ACC_BITS-1:0] acc_im_reg;
    logic signed [ACC_BITS-1:0] acc_re_next;
    logic signed [ACC_BITS-1:0] acc_im_next;
    logic signed [ACC_BITS-1:0] dump_re_reg;
    logic signed [ACC_BITS-1:0] dump_im_reg;
    logic signed [SUM_BITS-1:0] sum_re;
    logic signed [SUM_BITS-1:0] sum_im;

    // saturate a wide sum to the signed accumulator range
    function automatic logic signed [ACC_BITS-1:0] saturate(
        input logic signed [SUM_BITS-1:0] s
    );
        logic signed [ACC_BITS-1:0] r;
        if (s[SUM_BITS-1:ACC_BITS-1] == '0 || s[SUM_BITS-1:ACC_BITS-1] == '1) begin
            r = s[ACC_BITS-1:0];
        end else if (s[SUM_BITS-1]) begin
            r = {1'b1, {(ACC_BITS-1){1'b0}}};
        end else begin
            r = {1'b0, {(ACC_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    // multiplier stage
    always_ff @(posedge clk) begin
        p_rr_reg <= PW'(x_re) * PW'(y_re);
        p_ii_reg <= PW'(x_im) * PW'(y_im);
        p_ir_reg <= PW'(x_im) * PW'(y_re);
        p_ri_reg <= PW'(x_re) * PW'(y_im);
    end

    // real: xr*yr + xi*yi, imag: xi*yr - xr*yi
    always_comb begin
        sum_re = SUM_BITS'(acc_re_reg) + SUM_BITS'(p_rr_reg) + SUM_BITS'(p_ii_reg);
        sum_im = SUM_BITS'(acc_im_reg) + SUM_BITS'(p_ir_reg) - SUM_BITS'(p_ri_reg);
        acc_re_next = saturate(sum_re);
        acc_im_next = saturate(sum_im);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (ctl.acc) begin
            if (ctl.dump) begin
                acc_re_reg <= '0;
                acc_im_reg <= '0;
            end else begin
                acc_re_reg <= acc_re_next;
                acc_im_reg <= acc_im_next;
            end
        end
    end

    // dump chain link
    always_ff @(posedge clk) begin
        if (ctl.acc && ctl.dump) begin
            dump_re_reg <= acc_re_next;
            dump_im_reg <= acc_im_next;
        end else if (ctl.shift) begin
            dump_re_reg <= chain_re_in;
            dump_im_reg <= chain_im_in;
        end
    end

    assign chain_re_out = dump_re_reg;
    assign chain_im_out = dump_im_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tcc_drain.sv =====
// ----------------------------------------------------------------------------
// tcc_drain: output sequencer of the dump chain
// counts sums left and walks the station and polarization indices
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_drain (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load,
    input  wire logic                              out_stall,
    output logic                                   out_valid,
    output logic [tcc_pkg::IDX_OUT_BITS-1:0]       x_station,
    output logic [tcc_pkg::IDX_OUT_BITS-1:0]       y_station,
    output logic [tcc_pkg::POL_BITS-1:0]           pol_pair,
    output logic                                   last_result,
    output tcc_pkg::drain_stat_t                   stat
);

    localparam int CB = tcc_pkg::COUNT_BITS;
    localparam int XB = tcc_pkg::X_IDX_BITS;
    localparam int YB = tcc_pkg::Y_IDX_BITS;
    localparam int PB = tcc_pkg::POL_BITS;
    localparam int IB = tcc_pkg::IDX_OUT_BITS;

    logic [CB-1:0] count_reg;
    logic [CB-1:0] count_next;
    logic [XB-1:0] xs_reg;
    logic [XB-1:0] xs_next;
    logic [YB-1:0] ys_reg;
    logic [YB-1:0] ys_next;
    logic [PB-1:0] pol_reg;
    logic [PB-1:0] pol_next;
    logic          take;

    assign out_valid = (count_reg != '0);
    assign take      = out_valid && !out_stall;

    always_comb begin
        count_next = count_reg;
        xs_next    = xs_reg;
        ys_next    = ys_reg;
        pol_next   = pol_reg;
        if (load) begin
            count_next = CB'(tcc_pkg::NUM_SUMS);
            xs_next    = '0;
            ys_next    = '0;
            pol_next   = '0;
        end else if (take) begin
            count_next = count_reg - 1'b1;
            pol_next   = pol_reg + 1'b1;
            if (pol_reg == PB'(tcc_pkg::POL_PAIRS - 1)) begin
                if (xs_reg == XB'(tcc_pkg::X_STATIONS - 1)) begin
                    xs_next = '0;
                    ys_next = (ys_reg == YB'(tcc_pkg::Y_STATIONS - 1)) ? '0 : ys_reg + 1'b1;
                end else begin
                    xs_next = xs_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg <= '0;
            xs_reg    <= '0;
            ys_reg    <= '0;
            pol_reg   <= '0;
        end else begin
            count_reg <= count_next;
            xs_reg    <= xs_next;
            ys_reg    <= ys_next;
            pol_reg   <= pol_next;
        end
    end

    assign x_station   = IB'(xs_reg);
    assign y_station   = IB'(ys_reg);
    assign pol_pair    = pol_reg;
    assign last_result = (count_reg == CB'(1));
    assign stat.busy   = out_valid;
    assign stat.shift  = take;

`ifndef SYNTHESIS
    a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (count_reg == '0))
        else $error("dump loaded while chain still draining");

    a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (out_valid && count_reg == CB'(tcc_pkg::NUM_SUMS)))
        else $error("dump load did not fill the chain");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last_result) |=> !out_valid)
        else $error("word after the last result of a dump");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        last_result |-> (pol_reg == PB'(tcc_pkg::POL_PAIRS - 1)
            && xs_reg == XB'(tcc_pkg::X_STATIONS - 1)
            && ys_reg == YB'(tcc_pkg::Y_STATIONS - 1)))
        else $error("last result flagged at the wrong index");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tiled_cross_correlator_3x3_core.sv =====
// an accepted word is unpacked in stage 1, multiplied in stage 2, then added to the
// accumulators; a closing word loads its sums into the dump chain, offering the first.
// throughput: one sample word per cycle; a closing word waits while an earlier dump
// is in the two stages or the chain holds sums (36, one per cycle unless out_stall)
// reset: asynchronous, clears accumulators, valids and the drain count, not the chain
// ----------------------------------------------------------------------------
// tiled_cross_correlator_3x3_core: dual-polarization cross-correlator
// 3 x stations by 3 y stations, 36 saturating complex accumulator cells
// ----------------------------------------------------------------------------
`default_nettype none

module tiled_cross_correlator_3x3_core #(
    parameter int SAMPLE_BITS = 8,
    parameter int ACC_BITS    = 32
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    // input channel
    input  wire logic                                      in_valid,
    output logic                                           in_stall,
    input  wire logic [tcc_pkg::SAMPLE_WORD_BITS-1:0]      x0_sample,
    input  wire logic [tcc_pkg::SAMPLE_WORD_BITS-1:0]      x1_sample,
    input  wire logic [tcc_pkg::SAMPLE_WORD_BITS-1:0]      x2_sample,
    input  wire logic [tcc_pkg::SAMPLE_WORD_BITS-1:0]      y0_sample,
    input  wire logic [tcc_pkg::SAMPLE_WORD_BITS-1:0]      y1_sample,
    input  wire logic [tcc_pkg::SAMPLE_WORD_BITS-1:0]      y2_sample,
    input  wire logic                                      end_of_integration,
    // output channel
    output logic                                           out_valid,
    input  wire logic                                      out_stall,
    output logic [tcc_pkg::IDX_OUT_BITS-1:0]               x_station,
    output logic [tcc_pkg::IDX_OUT_BITS-1:0]               y_station,
    output logic [tcc_pkg::POL_BITS-1:0]                   pol_pair,
    output logic signed [tcc_pkg::SUM_OUT_BITS-1:0]        real_sum,
    output logic signed [tcc_pkg::SUM_OUT_BITS-1:0]        imag_sum,
    output logic                                           last_result
);

    localparam int NX   = tcc_pkg::X_STATIONS;
    localparam int NY   = tcc_pkg::Y_STATIONS;
    localparam int NS   = tcc_pkg::NUM_SUMS;
    localparam int WB   = tcc_pkg::SAMPLE_WORD_BITS;
    localparam int NC   = tcc_pkg::COMPS;
    localparam int WIDE = WB + NC * SAMPLE_BITS;
    localparam int OB   = tcc_pkg::SUM_OUT_BITS;
    localparam int EXT  = (ACC_BITS > OB) ? ACC_BITS : OB;

    // input words, one per station
    logic [WB-1:0] x_word [NX];
    logic [WB-1:0] y_word [NY];

    assign x_word[0] = x0_sample;
    assign x_word[1] = x1_sample;
    assign x_word[2] = x2_sample;
    assign y_word[0] = y0_sample;
    assign y_word[1] = y1_sample;
    assign y_word[2] = y2_sample;

    logic in_accept;

    // stage 1: unpacked components, index [station][component]
    // components re0, im0, re1, im1 from the low end; bits past the word read as 0
    logic signed [SAMPLE_BITS-1:0] x_comp_reg [NX][NC];
    logic signed [SAMPLE_BITS-1:0] y_comp_reg [NY][NC];
    logic                          s1_valid_reg;
    logic                          s1_last_reg;

    // stage 2: products sit in the cells, only control travels here
    logic                          s2_valid_reg;
    logic                          s2_last_reg;

    tcc_pkg::cell_ctl_t            cell_ctl;
    tcc_pkg::drain_stat_t          drain_stat;

    // dump chain, link 0 is the head; the tail is fed zeros
    logic signed [ACC_BITS-1:0]    chain_re [NS+1];
    logic signed [ACC_BITS-1:0]    chain_im [NS+1];
    logic signed [EXT-1:0]         head_re_ext;
    logic signed [EXT-1:0]         head_im_ext;

    // a closing word waits until no other dump is in flight or draining
    assign in_stall  = end_of_integration
                       && ((s1_valid_reg && s1_last_reg)
                           || (s2_valid_reg && s2_last_reg)
                           || drain_stat.busy);
    assign in_accept = in_valid && !in_stall;

    genvar gs, gc;
    generate
        for (gs = 0; gs < NX; gs++) begin : g_xunpack
            logic [WIDE-1:0] wide;
            assign wide = WIDE'(x_word[gs]);
            for (gc = 0; gc < NC; gc++) begin : g_comp
                always_ff @(posedge clk) begin
                    if (in_accept) begin
                        x_comp_reg[gs][gc] <= wide[gc*SAMPLE_BITS +: SAMPLE_BITS];
                    end
                end
            end
        end
        for (gs = 0; gs < NY; gs++) begin : g_yunpack
            logic [WIDE-1:0] wide;
            assign wide = WIDE'(y_word[gs]);
            for (gc = 0; gc < NC; gc++) begin : g_comp
                always_ff @(posedge clk) begin
                    if (in_accept) begin
                        y_comp_reg[gs][gc] <= wide[gc*SAMPLE_BITS +: SAMPLE_BITS];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= in_accept;
            s1_last_reg  <= end_of_integration;
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    assign cell_ctl.acc   = s2_valid_reg;
    assign cell_ctl.dump  = s2_valid_reg && s2_last_reg;
    assign cell_ctl.shift = drain_stat.shift;

    assign chain_re[NS] = '0;
    assign chain_im[NS] = '0;

    // cell order: y outermost, then x, then pol pair (2 * x pol + y pol)
    genvar gy, gx, gpx, gpy;
    generate
        for (gy = 0; gy < NY; gy++) begin : g_y
            for (gx = 0; gx < NX; gx++) begin : g_x
                for (gpx = 0; gpx < 2; gpx++) begin : g_px
                    for (gpy = 0; gpy < 2; gpy++) begin : g_py
                        localparam int K = (gy * NX + gx) * tcc_pkg::POL_PAIRS
                                           + 2 * gpx + gpy;
                        tcc_cell #(
                            .SAMPLE_BITS (SAMPLE_BITS),
                            .ACC_BITS    (ACC_BITS)
                        ) u_cell (
                            .clk          (clk),
                            .rst_n        (rst_n),
                            .x_re         (x_comp_reg[gx][2*gpx]),
                            .x_im         (x_comp_reg[gx][2*gpx+1]),
                            .y_re         (y_comp_reg[gy][2*gpy]),
                            .y_im         (y_comp_reg[gy][2*gpy+1]),
                            .ctl          (cell_ctl),
                            .chain_re_in  (chain_re[K+1]),
                            .chain_im_in  (chain_im[K+1]),
                            .chain_re_out (chain_re[K]),
                            .chain_im_out (chain_im[K])
                        );
                    end
                end
            end
        end
    endgenerate

    // output sequencing: counts the dump down and names each sum
    tcc_drain u_drain (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (cell_ctl.dump),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .x_station   (x_station),
        .y_station   (y_station),
        .pol_pair    (pol_pair),
        .last_result (last_result),
        .stat        (drain_stat)
    );

    // head of the chain, sign-extended then cut to the output width
    assign head_re_ext = EXT'(chain_re[0]);
    assign head_im_ext = EXT'(chain_im[0]);
    assign real_sum    = head_re_ext[OB-1:0];
    assign imag_sum    = head_im_ext[OB-1:0];

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tiled_cross_correlator_3x3_core
// each sample word goes into a software model of the 36 saturating sums. A
// closing word queues the 36 expected baseline sums, and the output monitor
// checks every result field by field. The run covers directed corner words, an
// integration of extreme words with large sums of both signs, and random
// integrations. The random part runs under four sender idle and receiver
// stall mixes, with a long receiver hold-off that backs up the dump chain.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    // watchdog limit, hold-off length and run lengths
    localparam int  WATCHDOG_LIMIT = 2000;
    localparam int  HOLD_CYCLES    = 400;
    localparam int  SETTLE_CYCLES  = 8;
    localparam int  SAT_WORDS      = 8;
    localparam int  SAT_TAIL_WORDS = 2;
    localparam int  PHASE_WORDS    = 50;
    localparam int  NUM_PHASES     = 4;

    localparam longint SUM_MAX = 2147483647;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    // extreme 8-bit components and the packed lane pairs built from them
    localparam logic [7:0]  LANE_MOST_NEG = 8'h80;
    localparam logic [7:0]  LANE_MOST_POS = 8'h7f;
    localparam logic [7:0]  LANE_ZERO     = 8'h00;
    localparam logic [7:0]  LANE_MINUS1   = 8'hff;
    localparam logic [15:0] POL_NEG_NEG   = 16'h8080;  // re -128, im -128
    localparam logic [15:0] POL_NEG_POS   = 16'h7f80;  // re -128, im 127
    localparam logic [15:0] POL_POS_POS   = 16'h7f7f;  // re 127, im 127

    typedef struct packed {
        logic [tcc_pkg::IDX_OUT_BITS-1:0] x_station;
        logic [tcc_pkg::IDX_OUT_BITS-1:0] y_station;
        logic [tcc_pkg::POL_BITS-1:0]     pol_pair;
        logic [tcc_pkg::SUM_OUT_BITS-1:0] real_sum;
        logic [tcc_pkg::SUM_OUT_BITS-1:0] imag_sum;
        logic                             last_result;
    } baseline_sum_t;

    // ------------------------------------------------------------------------
    // visibility book: software copy of the accumulators plus the queue of
    // dumped sums that the block still owes
    // ------------------------------------------------------------------------
    class visibility_book;
        longint        real_acc [tcc_pkg::NUM_SUMS];
        longint        imag_acc [tcc_pkg::NUM_SUMS];
        baseline_sum_t owed_sums [$];
        int            failures;
        int            dumps;
        int            compared;

        function new();
            int k;
            for (k = 0; k < tcc_pkg::NUM_SUMS; k++)
            begin
                real_acc[k] = 0;
                imag_acc[k] = 0;
            end
            failures = 0;
            dumps    = 0;
            compared = 0;
        endfunction

        function longint lane(logic [31:0] w, int idx);
            byte b;
            b = w[8*idx +: 8];
            return b;
        endfunction

        function longint clip(longint s);
            if (s > SUM_MAX)
                return SUM_MAX;
            if (s < SUM_MIN)
                return SUM_MIN;
            return s;
        endfunction

        function int pending();
            return owed_sums.size();
        endfunction

        // accumulate one accepted word; a closing word queues the whole dump
        function void note_word(logic [31:0] x0, logic [31:0] x1, logic [31:0] x2,
                                logic [31:0] y0, logic [31:0] y1, logic [31:0] y2,
                                logic closing);
            logic [31:0]   xw [tcc_pkg::X_STATIONS];
            logic [31:0]   yw [tcc_pkg::Y_STATIONS];
            longint        xr [tcc_pkg::X_STATIONS][2];
            longint        xi [tcc_pkg::X_STATIONS][2];
            longint        yr [tcc_pkg::Y_STATIONS][2];
            longint        yi [tcc_pkg::Y_STATIONS][2];
            int            x;
            int            y;
            int            px;
            int            py;
            int            k;
            baseline_sum_t s;
            xw[0] = x0;
            xw[1] = x1;
            xw[2] = x2;
            yw[0] = y0;
            yw[1] = y1;
            yw[2] = y2;
            for (x = 0; x < tcc_pkg::X_STATIONS; x++)
                for (px = 0; px < 2; px++)
                begin
                    xr[x][px] = lane(xw[x], 2 * px);
                    xi[x][px] = lane(xw[x], 2 * px + 1);
                end
            for (y = 0; y < tcc_pkg::Y_STATIONS; y++)
                for (py = 0; py < 2; py++)
                begin
                    yr[y][py] = lane(yw[y], 2 * py);
                    yi[y][py] = lane(yw[y], 2 * py + 1);
                end
            for (y = 0; y < tcc_pkg::Y_STATIONS; y++)
                for (x = 0; x < tcc_pkg::X_STATIONS; x++)
                    for (px = 0; px < 2; px++)
                        for (py = 0; py < 2; py++)
                        begin
                            k = (y * tcc_pkg::X_STATIONS + x) * tcc_pkg::POL_PAIRS
                                + 2 * px + py;
                            real_acc[k] = clip(real_acc[k]
                                + xr[x][px] * yr[y][py] + xi[x][px] * yi[y][py]);
                            imag_acc[k] = clip(imag_acc[k]
                                + xi[x][px] * yr[y][py] - xr[x][px] * yi[y][py]);
                        end
            if (!closing)
                return;
            dumps++;
            for (y = 0; y < tcc_pkg::Y_STATIONS; y++)
                for (x = 0; x < tcc_pkg::X_STATIONS; x++)
                    for (px = 0; px < tcc_pkg::POL_PAIRS; px++)
                    begin
                        k = (y * tcc_pkg::X_STATIONS + x) * tcc_pkg::POL_PAIRS + px;
                        s.x_station   = x[tcc_pkg::IDX_OUT_BITS-1:0];
                        s.y_station   = y[tcc_pkg::IDX_OUT_BITS-1:0];
                        s.pol_pair    = px[tcc_pkg::POL_BITS-1:0];
                        s.real_sum    = real_acc[k][tcc_pkg::SUM_OUT_BITS-1:0];
                        s.imag_sum    = imag_acc[k][tcc_pkg::SUM_OUT_BITS-1:0];
                        s.last_result = (k == tcc_pkg::NUM_SUMS - 1);
                        owed_sums.push_back(s);
                        real_acc[k] = 0;
                        imag_acc[k] = 0;
                    end
        endfunction

        // compare one delivered sum against the oldest owed one
        function void check_sum(logic [tcc_pkg::IDX_OUT_BITS-1:0] xs,
                                logic [tcc_pkg::IDX_OUT_BITS-1:0] ys,
                                logic [tcc_pkg::POL_BITS-1:0] pp,
                                logic [tcc_pkg::SUM_OUT_BITS-1:0] re,
                                logic [tcc_pkg::SUM_OUT_BITS-1:0] im, logic last);
            baseline_sum_t want;
            if (owed_sums.size() == 0)
            begin
                failures++;
                $error("result with no sum owed: x %0d y %0d pol %0d", xs, ys, pp);
                return;
            end
            want = owed_sums.pop_front();
            compared++;
            if (xs !== want.x_station)
            begin
                failures++;
                $error("x_station: expected %0d, got %0d", want.x_station, xs);
            end
            if (ys !== want.y_station)
            begin
                failures++;
                $error("y_station: expected %0d, got %0d", want.y_station, ys);
            end
            if (pp !== want.pol_pair)
            begin
                failures++;
                $error("pol_pair: expected %0d, got %0d", want.pol_pair, pp);
            end
            if (re !== want.real_sum)
            begin
                failures++;
                $error("real_sum: expected %0d, got %0d",
                       $signed(want.real_sum), $signed(re));
            end
            if (im !== want.imag_sum)
            begin
                failures++;
                $error("imag_sum: expected %0d, got %0d",
                       $signed(want.imag_sum), $signed(im));
            end
            if (last !== want.last_result)
            begin
                failures++;
                $error("last_result: expected %0d, got %0d", want.last_result, last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                                   in_valid           = 1'b0;
    logic                                   in_stall;
    logic [tcc_pkg::SAMPLE_WORD_BITS-1:0]   x0_sample          = '0;
    logic [tcc_pkg::SAMPLE_WORD_BITS-1:0]   x1_sample          = '0;
    logic [tcc_pkg::SAMPLE_WORD_BITS-1:0]   x2_sample          = '0;
    logic [tcc_pkg::SAMPLE_WORD_BITS-1:0]   y0_sample          = '0;
    logic [tcc_pkg::SAMPLE_WORD_BITS-1:0]   y1_sample          = '0;
    logic [tcc_pkg::SAMPLE_WORD_BITS-1:0]   y2_sample          = '0;
    logic                                   end_of_integration = 1'b0;

    logic                                   out_valid;
    logic                                   out_stall          = 1'b0;
    logic [tcc_pkg::IDX_OUT_BITS-1:0]       x_station;
    logic [tcc_pkg::IDX_OUT_BITS-1:0]       y_station;
    logic [tcc_pkg::POL_BITS-1:0]           pol_pair;
    logic signed [tcc_pkg::SUM_OUT_BITS-1:0] real_sum;
    logic signed [tcc_pkg::SUM_OUT_BITS-1:0] imag_sum;
    logic                                   last_result;

    // traffic shaping, set by the main sequence per phase
    int   gap_pct   = 0;
    int   stall_pct = 0;

    // hold-off request: a toggle so that only the receiver writes its counter
    logic hold_req  = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    int   words_sent = 0;
    int   quiet      = 0;

    visibility_book book;

    always #5 clk = ~clk;

    tiled_cross_correlator_3x3_core u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .x0_sample          (x0_sample),
        .x1_sample          (x1_sample),
        .x2_sample          (x2_sample),
        .y0_sample          (y0_sample),
        .y1_sample          (y1_sample),
        .y2_sample          (y2_sample),
        .end_of_integration (end_of_integration),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .x_station          (x_station),
        .y_station          (y_station),
        .pol_pair           (pol_pair),
        .real_sum           (real_sum),
        .imag_sum           (imag_sum),
        .last_result        (last_result)
    );

    // ------------------------------------------------------------------------
    // receiver: random stall, or a long hold-off when one is requested
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_seen <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_req != hold_seen)
        begin
            // new hold-off: keep the output blocked so the dump chain fills
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // output monitor: every accepted result is checked against the book
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.check_sum(x_station, y_station, pol_pair, real_sum, imag_sum,
                           last_result);
    end

    // watchdog: too many cycles with no word moving on either side
    initial
    begin
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sender tasks
    // ------------------------------------------------------------------------

    // offer one sample word after a random gap and hold it until accepted;
    // valid stays high on return so back-to-back words need no extra step
    task automatic send_word(input logic [31:0] x0, input logic [31:0] x1,
                             input logic [31:0] x2, input logic [31:0] y0,
                             input logic [31:0] y1, input logic [31:0] y2,
                             input logic closing);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid           <= 1'b1;
        x0_sample          <= x0;
        x1_sample          <= x1;
        x2_sample          <= x2;
        y0_sample          <= y0;
        y1_sample          <= y1;
        y2_sample          <= y2;
        end_of_integration <= closing;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.note_word(x0, x1, x2, y0, y1, y2, closing);
        words_sent++;
    endtask

    // drop valid and wait until every owed sum has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    // random sample word, with extreme components mixed in per lane
    function automatic logic [31:0] pick_sample();
        logic [31:0] w;
        int          i;
        w = $urandom;
        for (i = 0; i < 4; i++)
        begin
            case ($urandom_range(7))
                0: w[8*i +: 8] = LANE_MOST_NEG;
                1: w[8*i +: 8] = LANE_MOST_POS;
                2: w[8*i +: 8] = LANE_ZERO;
                3: w[8*i +: 8] = LANE_MINUS1;
                default: ;
            endcase
        end
        return w;
    endfunction

    task automatic send_random_word(input logic closing);
        send_word(pick_sample(), pick_sample(), pick_sample(),
                  pick_sample(), pick_sample(), pick_sample(), closing);
    endtask

    // random integrations of a few words each; the last word always closes
    task automatic random_integrations(input int count);
        int n;
        for (n = 0; n < count; n++)
            send_random_word((n == count - 1) || ($urandom_range(5) == 0));
    endtask

    // one integration of extreme words: sums grow large, positive and
    // negative, on both real and imag; a short tail with y components
    // flipped, all but the second pair of y0, then pulls those sums back toward zero
    task automatic saturation_run();
        int n;
        for (n = 0; n < SAT_WORDS; n++)
            send_word({POL_NEG_POS, POL_NEG_NEG}, {POL_NEG_NEG, POL_NEG_NEG},
                      {POL_NEG_NEG, POL_NEG_POS}, {POL_NEG_POS, POL_NEG_NEG},
                      {POL_POS_POS, POL_NEG_NEG}, {POL_NEG_NEG, POL_POS_POS},
                      1'b0);
        for (n = 0; n < SAT_TAIL_WORDS; n++)
            send_word({POL_NEG_POS, POL_NEG_NEG}, {POL_NEG_NEG, POL_NEG_NEG},
                      {POL_NEG_NEG, POL_NEG_POS}, {POL_NEG_POS, POL_POS_POS},
                      {POL_NEG_NEG, POL_POS_POS}, {POL_POS_POS, POL_NEG_NEG},
                      n == SAT_TAIL_WORDS - 1);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int phase;
        book = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at full rate
        gap_pct   = 0;
        stall_pct = 0;
        // empty integration of zeros
        send_word('0, '0, '0, '0, '0, '0, 1'b1);
        // most negative everywhere, single-word integration
        send_word(32'h80808080, 32'h80808080, 32'h80808080,
                  32'h80808080, 32'h80808080, 32'h80808080, 1'b1);
        // mixed extremes accumulated over three words
        send_word(32'h7f7f7f7f, 32'h7f7f7f7f, 32'h7f7f7f7f,
                  32'h80808080, 32'h80808080, 32'h80808080, 1'b0);
        send_word(32'h80808080, 32'h80808080, 32'h80808080,
                  32'h7f7f7f7f, 32'h7f7f7f7f, 32'h7f7f7f7f, 1'b0);
        send_word(32'hffffffff, 32'h01010101, 32'hff01ff01,
                  32'h01010101, 32'hffffffff, 32'h01ff01ff, 1'b1);
        // distinct value per station and lane, catches ordering mistakes
        send_word(32'h04030201, 32'h08070605, 32'h0c0b0a09,
                  32'hf1f2f3f4, 32'h7f80ff01, 32'h11223344, 1'b1);
        // closing words back to back: the second waits for the chain
        send_word(32'h7f807f80, 32'h807f807f, 32'h00000000,
                  32'h7f807f80, 32'h807f807f, 32'h7f7f8080, 1'b1);
        send_random_word(1'b1);
        send_random_word(1'b1);
        send_random_word(1'b0);
        send_random_word(1'b1);
        wait_drained();

        saturation_run();
        wait_drained();

        // random phases: quiet, sender gaps, receiver stalls, both
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 64;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 64;
                end
                default:
                begin
                    gap_pct   = 17;
                    stall_pct = 17;
                end
            endcase
            if (phase == 0)
            begin
                // block the output while words keep coming so input stalls
                hold_req <= ~hold_req;
                random_integrations(40);
            end
            random_integrations(PHASE_WORDS);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run: %0d sample words, %0d dumps, %0d sums compared",
                 words_sent, book.dumps, book.compared);
        $display("run: covered corner words, extreme-valued sums, gaps and hold-off");
        if (book.failures == 0 && book.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
